>>> hw/rtl/argb_color_matrix_clamp_assert.svh
// Assertion macros for the colour matrix block.
// Needs clk and rst in the scope of the use; no other dependencies.
`ifndef ARGB_COLOR_MATRIX_CLAMP_ASSERT_SVH
`define ARGB_COLOR_MATRIX_CLAMP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACMC_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("acmc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ACMC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("acmc: next-cycle check failed");

`endif

>>> hw/rtl/acmc_pkg.sv
// Shared types and constants for the colour matrix block.
// No dependencies.
package acmc_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int LANE_W         = 16;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int FRAC_BITS      = 8;
  localparam int ALPHA_SHIFT    = 24;
  localparam logic [31:0] ALPHA_MASK = 32'hff000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP = 2'd3;

  localparam logic [CFG_W-1:0] RED_RESET   = 64'h0000_0000_0000_0100;
  localparam logic [CFG_W-1:0] GREEN_RESET = 64'h0000_0000_0100_0000;
  localparam logic [CFG_W-1:0] BLUE_RESET  = 64'h0000_0100_0000_0000;

  typedef struct packed {
    logic [31:0] pixel_in;
    logic        in_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] red;
    logic [CFG_W-1:0] green;
    logic [CFG_W-1:0] blue;
    logic             clamp;
  } cfg_t;

  // per-stage load enables
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ctl_t;

endpackage

>>> hw/rtl/acmc_cfg.sv
// Configuration registers: three packed weight sets and the clamp switch.
// Depends on acmc_pkg.
module acmc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [acmc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [acmc_pkg::CFG_W-1:0]    cfg_data,
  output acmc_pkg::cfg_t                cfg
);
  import acmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red   <= RED_RESET;
      cfg.green <= GREEN_RESET;
      cfg.blue  <= BLUE_RESET;
      cfg.clamp <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RED:   cfg.red   <= cfg_data;
        REG_GREEN: cfg.green <= cfg_data;
        REG_BLUE:  cfg.blue  <= cfg_data;
        REG_CLAMP: cfg.clamp <= cfg_data[0];
      endcase
    end
  end

endmodule

>>> hw/rtl/acmc_chan.sv
// One output colour channel: multiply, sum, then shift and clamp,
// one register stage each. Depends on acmc_pkg.
module acmc_chan #(
  parameter int COEF_WIDTH = acmc_pkg::COEF_WIDTH_DEF
) (
  input  logic                       clk,
  input  acmc_pkg::stage_ctl_t       ctl,
  input  logic [31:0]                pixel,
  input  logic [acmc_pkg::CFG_W-1:0] coeffs,
  input  logic                       clamp,
  input  logic [7:0]                 alpha_s2,
  output logic [7:0]                 chan
);
  import acmc_pkg::*;

  localparam int PROD_W = COEF_WIDTH + 9;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q_W    = SUM_W - FRAC_BITS;

  logic signed [8:0]        px [4];
  logic signed [PROD_W-1:0] prod [4];
  logic signed [SUM_W-1:0]  sum;
  logic signed [Q_W-1:0]    q;
  logic signed [Q_W-1:0]    a_ext;
  logic [7:0]               chan_next;

  // lane order r, g, b, a
  assign px[0] = $signed({1'b0, pixel[23:16]});
  assign px[1] = $signed({1'b0, pixel[15:8]});
  assign px[2] = $signed({1'b0, pixel[7:0]});
  assign px[3] = $signed({1'b0, pixel[31:ALPHA_SHIFT]});

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= $signed(coeffs[k*LANE_W +: COEF_WIDTH]) * px[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      sum <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    end
  end

  // dropping the fraction bits floors toward minus infinity
  assign q     = $signed(sum[SUM_W-1:FRAC_BITS]);
  assign a_ext = $signed({{(Q_W-8){1'b0}}, alpha_s2});

  always_comb begin
    if (!clamp) begin
      chan_next = q[7:0];
    end else if (q[Q_W-1]) begin
      chan_next = 8'd0;
    end else if (q > a_ext) begin
      chan_next = alpha_s2;
    end else begin
      chan_next = q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      chan <= chan_next;
    end
  end

endmodule

>>> hw/rtl/argb_color_matrix_clamp.sv
// Top level of the premultiplied ARGB colour matrix with clamp.
// Depends on acmc_pkg, acmc_cfg, acmc_chan and argb_color_matrix_clamp_assert.svh.
//
//  channel   signals                        payload
//  input     in_valid / in_ready            in_item  (pixel_in, in_last)
//  output    out_valid / out_ready          out_item (pixel_out, out_last)
//  config    cfg_we, cfg_idx                cfg_data (64 bits, no read-back)
//
// Three register stages (products, sums, shift and clamp), one pixel per clock
// sustained if out_ready is high. Each multiplier feeds its own stage register.
// Stalls back-pressure stage by stage; empty stages fill while the output waits.
// Synchronous reset clears the valid bits and loads the default weights.
module argb_color_matrix_clamp #(
  parameter int COEF_WIDTH = acmc_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  acmc_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output acmc_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [acmc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [acmc_pkg::CFG_W-1:0]     cfg_data
);
  import acmc_pkg::*;

  cfg_t       cfg;
  stage_ctl_t ctl;
  logic       v1, v2, v3;
  logic       free1, free2, free3;
  logic [7:0] a1, a2, a3;
  logic       last1, last2, last3;
  logic [7:0] red, green, blue;

  // a stage may load when it is empty or its item moves on
  assign free3 = !v3 || out_ready;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;
  assign in_ready = free1;

  assign ctl = '{ld1: free1, ld2: free2, ld3: free3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (free1) v1 <= in_valid;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
    end
  end

  // alpha and last flag travel alongside the channel pipelines
  always_ff @(posedge clk) begin
    if (free1) begin
      a1    <= in_item.pixel_in[31:ALPHA_SHIFT];
      last1 <= in_item.in_last;
    end
    if (free2) begin
      a2    <= a1;
      last2 <= last1;
    end
    if (free3) begin
      a3    <= a2;
      last3 <= last2;
    end
  end

  acmc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  acmc_chan #(.COEF_WIDTH(COEF_WIDTH)) u_red (
    .clk      (clk),
    .ctl      (ctl),
    .pixel    (in_item.pixel_in),
    .coeffs   (cfg.red),
    .clamp    (cfg.clamp),
    .alpha_s2 (a2),
    .chan     (red)
  );

  acmc_chan #(.COEF_WIDTH(COEF_WIDTH)) u_green (
    .clk      (clk),
    .ctl      (ctl),
    .pixel    (in_item.pixel_in),
    .coeffs   (cfg.green),
    .clamp    (cfg.clamp),
    .alpha_s2 (a2),
    .chan     (green)
  );

  acmc_chan #(.COEF_WIDTH(COEF_WIDTH)) u_blue (
    .clk      (clk),
    .ctl      (ctl),
    .pixel    (in_item.pixel_in),
    .coeffs   (cfg.blue),
    .clamp    (cfg.clamp),
    .alpha_s2 (a2),
    .chan     (blue)
  );

  assign out_valid          = v3;
  assign out_item.pixel_out = ({a3, 24'd0} & ALPHA_MASK) | {8'd0, red, green, blue};
  assign out_item.out_last  = last3;

`include "argb_color_matrix_clamp_assert.svh"

  // premultiplied: with clamping no colour exceeds alpha
  `ACMC_ASSERT_NOW(a_clamp_bound, v3 && cfg.clamp, red <= a3 && green <= a3 && blue <= a3)
  // an item in stage one moves on whenever stage two can take it
  `ACMC_ASSERT_NEXT(a_advance, v1 && free2, v2)
  // a blocked middle stage keeps its item
  `ACMC_ASSERT_NEXT(a_hold_mid, v2 && !free3, v2 && $stable(a2) && $stable(last2))

endmodule
